### hw/rtl/assert_macros.svh
// Assertion macros shared by the fill engine RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent, outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/crfe_pkg.sv
// Shared types and constants of the clipped rectangle fill engine.
// Used by the front, the job queue, the back and the top level; depends on nothing.
package crfe_pkg;

  // Window store geometry.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int XW         = $clog2(MAX_WIDTH + 1);
  localparam int YW         = $clog2(MAX_HEIGHT + 1);

  // Fixed field widths.
  localparam int REG_DIM_W  = 9;
  localparam int COLOR_W    = 32;
  localparam int COORD_IN_W = 11;

  // Signed width for clipping math; holds coordinate sums and window sizes.
  localparam int DIM_MAX_W  = (XW > YW) ? XW : YW;
  localparam int CW         = ((DIM_MAX_W > COORD_IN_W) ? DIM_MAX_W : COORD_IN_W) + 2;

  // Command opcodes.
  localparam logic [1:0] OP_FILL     = 2'd0;
  localparam logic [1:0] OP_DECORATE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // Decoration colors and geometry.
  localparam logic [COLOR_W-1:0] TITLE_COLOR = 32'h001A1F2B;
  localparam logic [COLOR_W-1:0] BTN_A_COLOR = 32'h00FFD166;
  localparam logic [COLOR_W-1:0] BTN_B_COLOR = 32'h00E76F51;
  localparam logic [COLOR_W-1:0] RULE_COLOR  = 32'h003F4D62;
  localparam int TITLE_HEIGHT  = 18;
  localparam int RULE_STEP     = 22;
  localparam int RULE_START    = 30;
  localparam int BTN_Y         = 5;
  localparam int BTN_H         = 8;
  localparam int BTN_A_X       = 8;
  localparam int BTN_A_W       = 8;
  localparam int BTN_B_INSET   = 18;
  localparam int BTN_B_W       = 10;
  localparam int RULE_X        = 10;
  localparam int RULE_INSET    = 20;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  // What the back does with one job.
  typedef enum logic [1:0] {
    JOB_NOP  = 2'd0,
    JOB_FILL = 2'd1,
    JOB_READ = 2'd2
  } job_kind_t;

  // One clipped job; the last job of a command carries its result status.
  typedef struct packed {
    job_kind_t            kind;
    logic [XW-1:0]        left;
    logic [YW-1:0]        top;
    logic [XW-1:0]        right;
    logic [YW-1:0]        bottom;
    logic [XW-1:0]        pitch;
    logic [COLOR_W-1:0]   color;
    logic                 last;
    status_t              status;
  } job_t;

  // Configuration register contents.
  typedef struct packed {
    logic [REG_DIM_W-1:0] win_w;
    logic [REG_DIM_W-1:0] win_h;
    logic [COLOR_W-1:0]   bg;
  } cfg_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hw/rtl/crfe_front.sv
// Front end of the fill engine: accepts commands, clips them and expands decorate.
// Pushes clipped jobs into the job queue; uses crfe_pkg.
module crfe_front (
  input  logic                             clk,
  input  logic                             rst,
  input  crfe_pkg::cfg_t                   cfg,
  input  logic                             clearing,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_x,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_y,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_width,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_height,
  input  logic [crfe_pkg::COLOR_W-1:0]     fill_color,
  input  crfe_pkg::q_status_t              q_stat,
  output logic                             q_push,
  output crfe_pkg::job_t                   q_job
);

  localparam int CW = crfe_pkg::CW;
  localparam int XW = crfe_pkg::XW;
  localparam int YW = crfe_pkg::YW;

  localparam logic signed [CW-1:0] K_ZERO     = CW'(0);
  localparam logic signed [CW-1:0] K_ONE      = CW'(1);
  localparam logic signed [CW-1:0] K_TITLE_H  = CW'(crfe_pkg::TITLE_HEIGHT);
  localparam logic signed [CW-1:0] K_STEP     = CW'(crfe_pkg::RULE_STEP);
  localparam logic signed [CW-1:0] K_START    = CW'(crfe_pkg::RULE_START);
  localparam logic signed [CW-1:0] K_BTN_Y    = CW'(crfe_pkg::BTN_Y);
  localparam logic signed [CW-1:0] K_BTN_H    = CW'(crfe_pkg::BTN_H);
  localparam logic signed [CW-1:0] K_BTN_A_X  = CW'(crfe_pkg::BTN_A_X);
  localparam logic signed [CW-1:0] K_BTN_A_W  = CW'(crfe_pkg::BTN_A_W);
  localparam logic signed [CW-1:0] K_BTN_B_IN = CW'(crfe_pkg::BTN_B_INSET);
  localparam logic signed [CW-1:0] K_BTN_B_W  = CW'(crfe_pkg::BTN_B_W);
  localparam logic signed [CW-1:0] K_RULE_X   = CW'(crfe_pkg::RULE_X);
  localparam logic signed [CW-1:0] K_RULE_IN  = CW'(crfe_pkg::RULE_INSET);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CMD  = 3'b010,
    F_DECO = 3'b100
  } front_state_t;

  typedef enum logic [4:0] {
    D_BG    = 5'b00001,
    D_TITLE = 5'b00010,
    D_BTNA  = 5'b00100,
    D_BTNB  = 5'b01000,
    D_RULE  = 5'b10000
  } deco_step_t;

  front_state_t                     state;
  deco_step_t                       dstep;
  logic signed [CW-1:0]             rule_row;
  logic [1:0]                       op_q;
  logic signed [CW-1:0]             x_q;
  logic signed [CW-1:0]             y_q;
  logic signed [CW-1:0]             w_q;
  logic signed [CW-1:0]             h_q;
  logic [crfe_pkg::COLOR_W-1:0]     color_q;

  logic [XW-1:0]                    ww_eff;
  logic [YW-1:0]                    wh_eff;
  logic signed [CW-1:0]             ww;
  logic signed [CW-1:0]             wh;
  logic                             win_ok;
  logic                             read_inside;
  logic                             cmd_push;
  logic                             deco_push;
  crfe_pkg::job_t                   cmd_job;
  crfe_pkg::job_t                   deco_job;

  // Clip a signed rectangle to the window and turn it into a job.
  function automatic crfe_pkg::job_t make_fill(
    input logic signed [CW-1:0]         x,
    input logic signed [CW-1:0]         y,
    input logic signed [CW-1:0]         w,
    input logic signed [CW-1:0]         h,
    input logic signed [CW-1:0]         win_w,
    input logic signed [CW-1:0]         win_h,
    input logic [crfe_pkg::COLOR_W-1:0] color,
    input logic                         last
  );
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] top;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] bottom;
    logic                 empty;
    crfe_pkg::job_t       j;
    left   = (x < K_ZERO) ? K_ZERO : x;
    top    = (y < K_ZERO) ? K_ZERO : y;
    right  = x + w;
    bottom = y + h;
    if (right > win_w) right = win_w;
    if (bottom > win_h) bottom = win_h;
    empty = (win_w <= K_ZERO) || (win_h <= K_ZERO) || (w <= K_ZERO) || (h <= K_ZERO) ||
            (left >= right) || (top >= bottom);
    j.kind   = empty ? crfe_pkg::JOB_NOP : crfe_pkg::JOB_FILL;
    j.left   = left[XW-1:0];
    j.top    = top[YW-1:0];
    j.right  = right[XW-1:0];
    j.bottom = bottom[YW-1:0];
    j.pitch  = win_w[XW-1:0];
    j.color  = color;
    j.last   = last;
    j.status = crfe_pkg::ST_DONE;
    return j;
  endfunction

  // Effective window size saturates at the store dimensions.
  always_comb begin
    ww_eff = (32'(cfg.win_w) > crfe_pkg::MAX_WIDTH)  ? XW'(crfe_pkg::MAX_WIDTH)  : XW'(cfg.win_w);
    wh_eff = (32'(cfg.win_h) > crfe_pkg::MAX_HEIGHT) ? YW'(crfe_pkg::MAX_HEIGHT) : YW'(cfg.win_h);
    ww     = CW'(ww_eff);
    wh     = CW'(wh_eff);
    win_ok = (ww_eff != '0) && (wh_eff != '0);
  end

  // Job for a single fill, read or empty command.
  always_comb begin
    read_inside = (x_q >= K_ZERO) && (y_q >= K_ZERO) && (x_q < ww) && (y_q < wh);
    cmd_job = make_fill(x_q, y_q, w_q, h_q, ww, wh, color_q, 1'b1);
    case (op_q)
      crfe_pkg::OP_FILL: begin
        cmd_job.status = (cmd_job.kind == crfe_pkg::JOB_FILL) ? crfe_pkg::ST_DONE
                                                              : crfe_pkg::ST_EMPTY;
      end
      crfe_pkg::OP_READ: begin
        cmd_job.left   = x_q[XW-1:0];
        cmd_job.top    = y_q[YW-1:0];
        cmd_job.kind   = read_inside ? crfe_pkg::JOB_READ : crfe_pkg::JOB_NOP;
        cmd_job.status = read_inside ? crfe_pkg::ST_DONE : crfe_pkg::ST_OUTSIDE;
      end
      default: begin
        // Decorate on an empty window and the unused opcode draw nothing.
        cmd_job.kind   = crfe_pkg::JOB_NOP;
        cmd_job.status = crfe_pkg::ST_EMPTY;
      end
    endcase
  end

  // Job for the current decoration step.
  always_comb begin
    case (dstep)
      D_BG:    deco_job = make_fill(K_ZERO, K_ZERO, ww, wh, ww, wh, cfg.bg, 1'b0);
      D_TITLE: deco_job = make_fill(K_ZERO, K_ZERO, ww, K_TITLE_H, ww, wh,
                                    crfe_pkg::TITLE_COLOR, 1'b0);
      D_BTNA:  deco_job = make_fill(K_BTN_A_X, K_BTN_Y, K_BTN_A_W, K_BTN_H, ww, wh,
                                    crfe_pkg::BTN_A_COLOR, 1'b0);
      D_BTNB:  deco_job = make_fill(ww - K_BTN_B_IN, K_BTN_Y, K_BTN_B_W, K_BTN_H, ww, wh,
                                    crfe_pkg::BTN_B_COLOR, K_START >= wh);
      D_RULE:  deco_job = make_fill(K_RULE_X, rule_row, ww - K_RULE_IN, K_ONE, ww, wh,
                                    crfe_pkg::RULE_COLOR, (rule_row + K_STEP) >= wh);
      default: deco_job = make_fill(K_ZERO, K_ZERO, K_ZERO, K_ZERO, ww, wh, cfg.bg, 1'b1);
    endcase
  end

  // Queue push and handshake.
  assign cmd_push  = (state == F_CMD) && !((op_q == crfe_pkg::OP_DECORATE) && win_ok) &&
                     !q_stat.full;
  assign deco_push = (state == F_DECO) && !q_stat.full;
  assign q_push    = cmd_push || deco_push;
  assign q_job     = (state == F_DECO) ? deco_job : cmd_job;
  assign in_ready  = (state == F_IDLE) && !clearing;

  // Command capture and decoration sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      dstep <= D_BG;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            op_q    <= opcode;
            x_q     <= CW'(rect_x);
            y_q     <= CW'(rect_y);
            w_q     <= CW'(rect_width);
            h_q     <= CW'(rect_height);
            color_q <= fill_color;
            state   <= F_CMD;
          end
        end
        F_CMD: begin
          if ((op_q == crfe_pkg::OP_DECORATE) && win_ok) begin
            dstep <= D_BG;
            state <= F_DECO;
          end else if (cmd_push) begin
            state <= F_IDLE;
          end
        end
        F_DECO: begin
          if (deco_push) begin
            case (dstep)
              D_BG:    dstep <= D_TITLE;
              D_TITLE: dstep <= D_BTNA;
              D_BTNA:  dstep <= D_BTNB;
              D_BTNB: begin
                rule_row <= K_START;
                if (deco_job.last) state <= F_IDLE;
                else dstep <= D_RULE;
              end
              D_RULE: begin
                rule_row <= rule_row + K_STEP;
                if (deco_job.last) state <= F_IDLE;
              end
              default: state <= F_IDLE;
            endcase
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/crfe_queue.sv
// Short job queue between the front and the back of the fill engine.
// Four entries of crfe_pkg::job_t with full and empty flags.
module crfe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  crfe_pkg::job_t      push_job,
  input  logic                pop,
  output crfe_pkg::job_t      head,
  output crfe_pkg::q_status_t stat
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  crfe_pkg::job_t   entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign stat.full  = (count == (QAW + 1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !stat.full) entries[wr_ptr] <= push_job;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !stat.full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !stat.empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !stat.full, pop && !stat.empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/crfe_back.sv
// Back end of the fill engine: pixel store, pixel writer, reader and result register.
// Takes jobs from the job queue; uses crfe_pkg.
module crfe_back (
  input  logic                         clk,
  input  logic                         rst,
  input  crfe_pkg::job_t               head,
  input  crfe_pkg::q_status_t          q_stat,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [crfe_pkg::COLOR_W-1:0] read_data,
  output logic [1:0]                   status
);

  localparam int AW = crfe_pkg::AW;
  localparam int XW = crfe_pkg::XW;
  localparam int YW = crfe_pkg::YW;

  typedef enum logic [5:0] {
    B_CLEAR  = 6'b000001,
    B_IDLE   = 6'b000010,
    B_LOAD   = 6'b000100,
    B_FILL   = 6'b001000,
    B_READ   = 6'b010000,
    B_FINISH = 6'b100000
  } back_state_t;

  back_state_t                  state;
  crfe_pkg::job_t               cur;
  logic [AW-1:0]                clear_addr;
  logic [AW-1:0]                addr;
  logic [AW-1:0]                row_addr;
  logic [XW-1:0]                col;
  logic [YW-1:0]                row;
  logic [XW-1:0]                col_inc;
  logic [YW-1:0]                row_inc;
  logic [YW+XW-1:0]             prod;
  logic [AW-1:0]                row_base;
  logic [AW-1:0]                next_row_addr;
  logic                         slot_free;

  logic [crfe_pkg::COLOR_W-1:0] mem [crfe_pkg::DEPTH];
  logic [crfe_pkg::COLOR_W-1:0] rd_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [crfe_pkg::COLOR_W-1:0] mem_wdata;

  // Address arithmetic for the current job.
  assign prod          = cur.top * cur.pitch;
  assign row_base      = AW'(prod) + AW'(cur.left);
  assign next_row_addr = row_addr + AW'(cur.pitch);
  assign col_inc       = col + XW'(1);
  assign row_inc       = row + YW'(1);

  assign clearing  = (state == B_CLEAR);
  assign q_pop     = (state == B_IDLE) && !q_stat.empty;
  assign slot_free = !out_valid || out_ready;

  // Store write port: the clearing pass or the pixel writer.
  assign mem_we    = (state == B_CLEAR) || (state == B_FILL);
  assign mem_waddr = (state == B_CLEAR) ? clear_addr : addr;
  assign mem_wdata = (state == B_CLEAR) ? '0 : cur.color;

  // Pixel store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state == B_READ) rd_q <= mem[addr];
  end

  // Job sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A result taken while the next one is loaded is replaced in B_FINISH.
      if (out_valid && out_ready && (state != B_FINISH)) out_valid <= 1'b0;
      case (state)
        B_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == AW'(crfe_pkg::DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_stat.empty) begin
            cur <= head;
            case (head.kind)
              crfe_pkg::JOB_FILL: state <= B_LOAD;
              crfe_pkg::JOB_READ: state <= B_LOAD;
              default:            state <= head.last ? B_FINISH : B_IDLE;
            endcase
          end
        end
        B_LOAD: begin
          addr     <= row_base;
          row_addr <= row_base;
          col      <= cur.left;
          row      <= cur.top;
          state    <= (cur.kind == crfe_pkg::JOB_READ) ? B_READ : B_FILL;
        end
        B_FILL: begin
          // One pixel per cycle, row by row.
          if (col_inc == cur.right) begin
            if (row_inc == cur.bottom) begin
              state <= cur.last ? B_FINISH : B_IDLE;
            end else begin
              row      <= row_inc;
              col      <= cur.left;
              row_addr <= next_row_addr;
              addr     <= next_row_addr;
            end
          end else begin
            col  <= col_inc;
            addr <= addr + 1'b1;
          end
        end
        B_READ: begin
          state <= B_FINISH;
        end
        B_FINISH: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            read_data <= (cur.kind == crfe_pkg::JOB_READ) ? rd_q : '0;
            status    <= cur.status;
            state     <= B_IDLE;
          end else begin
            out_valid <= out_valid;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/clipped_rectangle_fill_engine.sv
// Top level of the clipped rectangle fill engine: configuration registers and wiring.
// Instantiates crfe_front, crfe_queue and crfe_back; uses crfe_pkg and assert_macros.svh.
//
// Usage:
//   Commands enter on the in_valid/in_ready channel (opcode, rectangle, fill_color) and
//   each yields exactly one result transaction (read_data, status) on out_valid/out_ready,
//   in command order. Configuration goes through the APB port while the block is idle.
// Job flow:
//   The front takes no new command until it has pushed the jobs of the last one into a
//   four-entry queue. The back pops a job, sets up its addresses, then writes one pixel
//   per cycle; a read adds a store access, and the last job of a command loads the
//   result into the output register.
// Reset:
//   After reset the back runs a clearing pass over all 65536 store words, one per cycle;
//   in_ready stays low until the pass ends. APB writes are taken throughout.
// Stalls:
//   A finished result waits in the output register; the back halts on a command's last
//   job until it is free; with the queue full the front holds its job and takes no command.
module clipped_rectangle_fill_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             opcode,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_x,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_y,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_width,
  input  logic signed [crfe_pkg::COORD_IN_W-1:0] rect_height,
  input  logic [crfe_pkg::COLOR_W-1:0]           fill_color,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [crfe_pkg::COLOR_W-1:0]           read_data,
  output logic [1:0]                             status
);

  `include "assert_macros.svh"

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  crfe_pkg::cfg_t      cfg;
  crfe_pkg::q_status_t q_stat;
  crfe_pkg::job_t      q_job;
  crfe_pkg::job_t      q_head;
  logic                q_push;
  logic                q_pop;
  logic                clearing;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_w <= crfe_pkg::REG_DIM_W'(256);
      cfg.win_h <= crfe_pkg::REG_DIM_W'(256);
      cfg.bg    <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg.win_w <= pwdata[crfe_pkg::REG_DIM_W-1:0];
        REG_HEIGHT: cfg.win_h <= pwdata[crfe_pkg::REG_DIM_W-1:0];
        REG_BG:     cfg.bg    <= pwdata;
        default:    ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg.win_w);
      REG_HEIGHT: prdata = 32'(cfg.win_h);
      REG_BG:     prdata = cfg.bg;
      default:    prdata = '0;
    endcase
  end

  crfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clearing    (clearing),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .fill_color  (fill_color),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  crfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  crfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status)
  );

  // The front never pushes into a full queue, and the back never pops an empty one.
  `ASSERT_IMPLIES(a_push_not_full, clk, rst, q_push, !q_stat.full, "push into full queue")
  `ASSERT_IMPLIES(a_pop_not_empty, clk, rst, q_pop, !q_stat.empty, "pop from empty queue")
  // No command is taken and no result appears while the store is being cleared.
  `ASSERT_IMPLIES(a_clear_no_input, clk, rst, clearing, !in_ready, "input taken in clear")
  `ASSERT_ALWAYS(a_clear_no_result, clk, rst, !(clearing && out_valid), "result in clear")

endmodule
